// ----- sv/acs_pkg.sv -----
// Shared types and fixed constants for the audio chunk crossfade splicer.
// No dependencies; imported by the top level and the port checker.
`default_nettype none

package acs_pkg;

  // Ring geometry and count widths (ring depth is fixed at 4096 entries)
  localparam int RING_DEPTH = 4096;
  localparam int RING_AW    = 12;
  localparam int CNT_W      = 12;
  localparam int HELD_W     = 13;
  localparam int SINE_W     = 16;
  localparam int CFG_DATA_W = 31;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CNT_W-1:0] CNT_SAT   = 12'd4095;
  localparam logic [13:0]      OCC_LIMIT = 14'd4095;

  // pi/2 in Q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_PULL   = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_REFUSED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MODE_FIRST = 2'd0,
    MODE_LATER = 2'd1,
    MODE_DONE  = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUIET_LEVEL = 1'b0,
    CFG_MIN_FADE    = 1'b1
  } cfg_idx_t;

  localparam logic [30:0] QUIET_LEVEL_RST = 31'd429497;
  localparam logic [13:0] MIN_FADE_RST    = 14'd480;

endpackage

`default_nettype wire

// ----- sv/acs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module acs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- sv/audio_chunk_crossfade_splicer_top.sv -----
// Top level of the audio chunk crossfade splicer: control FSM, crossfade datapath, sine ROM.
// Depends on acs_pkg and acs_ram (sample ring).
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------------
//   in_     | in        | in_valid/in_stall | in_opcode, in_sample_in
//   out_    | out       | out_valid/out_stall | out_status, out_sample_out, out_final_sample
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Push and ignored ops need no ring read; a pull does one ring read.
// A close or finish that splices onto held output scans the qt quiet tail
// samples, runs the D/n divider, mixes the n crossfade samples and then shifts
// the other len-n samples of the chunk, with n the crossfade length and len
// the chunk length; the single ring read port serializes these reads.
// Reset: synchronous, clears pointers, counters and mode; ring is not cleared.
// Stalls: the output register holds a result while out_stall is high; the
// next item is still accepted and worked on, and waits to emit until it frees.
`default_nettype none

module audio_chunk_crossfade_splicer_top
  import acs_pkg::*;
#(
  parameter int FADE_MAX         = 2048,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS      = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_opcode,
  input  logic signed [15:0]    in_sample_in,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic signed [15:0]    out_sample_out,
  output logic                  out_final_sample,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int TW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int BW    = $clog2(TW);
  localparam int SQ_W  = 2 * SB;
  localparam int CMP_W = (SQ_W > CFG_DATA_W) ? SQ_W : CFG_DATA_W;

  localparam logic [13:0]        FADE_V   = 14'(FADE_MAX);
  localparam logic [TW-1:0]      D_V      = TW'(SINE_TABLE_DEPTH);
  localparam logic signed [SB+17:0] MIX_RND = (SB+18)'(16384);
  localparam logic signed [SB+2:0]  MIX_HI  = (SB+3)'((1 << (SB - 1)) - 1);
  localparam logic signed [SB+2:0]  MIX_LO  = ~MIX_HI;
  localparam int unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

  // ---------------------------------------------------------------------------
  // Quarter-sine ROM, built at elaboration by a Q30 Taylor series to x^13
  // ---------------------------------------------------------------------------
  typedef logic [SINE_W-1:0] sine_rom_t [SINE_TABLE_DEPTH+1];

  function automatic sine_rom_t build_sine();
    sine_rom_t          tab;
    logic [63:0]        x;
    logic [63:0]        term;
    logic [63:0]        q;
    logic signed [63:0] sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (64'(k) * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      term = x;
      sum = $signed(x);
      for (int j = 1; j <= 6; j++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'(TAYLOR_DIV[j-1]);
        if ((j & 1) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = '0;
      end
      q = (64'(sum) + 64'd16384) >> 15;
      if (q > 64'd32768) begin
        q = 64'd32768;
      end
      tab[k] = q[SINE_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // Input sample to ring width: low SAMPLE_BITS of the zero-extended 16-bit field
  function automatic logic [SB-1:0] to_ring(input logic [15:0] v);
    logic [SB+15:0] z;
    z = {{SB{1'b0}}, v};
    return z[SB-1:0];
  endfunction

  // Ring entry to output field: low 16 bits of the sign-extended sample
  function automatic logic [15:0] to_out(input logic [SB-1:0] v);
    logic signed [SB+15:0] e;
    e = (SB+16)'($signed(v));
    return e[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------------
  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_PULL     = 13'b0000000000010,
    S_SCAN_RD  = 13'b0000000000100,
    S_SCAN_CHK = 13'b0000000001000,
    S_SEL      = 13'b0000000010000,
    S_DIV      = 13'b0000000100000,
    S_MIX_RD_D = 13'b0000001000000,
    S_MIX_RD_S = 13'b0000010000000,
    S_MIX_MUL  = 13'b0000100000000,
    S_MIX_WR   = 13'b0001000000000,
    S_SH_RD    = 13'b0010000000000,
    S_SH_WR    = 13'b0100000000000,
    S_FIN      = 13'b1000000000000
  } state_t;

  // Emit is folded into a flag so the FSM enum stays one state per job
  state_t state_r, state_nxt;
  logic   emit_r, emit_nxt;

  // Architectural state
  mode_t              mode_r, mode_nxt;
  logic [RING_AW-1:0] rp_r, rp_nxt;
  logic [RING_AW-1:0] wp_r, wp_nxt;
  logic [HELD_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   qhead_r, qhead_nxt;
  logic               loud_r, loud_nxt;
  logic [30:0]        qlvl_r;
  logic [13:0]        minfade_r;

  // Splice working registers
  logic [RING_AW-1:0] start_r, start_nxt;
  logic [CNT_W-1:0]   cap_r, cap_nxt;
  logic [CNT_W-1:0]   qt_r, qt_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [TW-1:0]      j_r, j_nxt;
  logic [TW-1:0]      a_r, a_nxt;
  logic [CNT_W:0]     b_r, b_nxt;
  logic [CNT_W:0]     r_r, r_nxt;
  logic [CNT_W:0]     rem_r, rem_nxt;
  logic [BW-1:0]      bit_r, bit_nxt;
  logic               fin_r, fin_nxt;

  // Result waiting for the output register
  status_t     res_status_r, res_status_nxt;
  logic [15:0] res_sample_r, res_sample_nxt;
  logic        res_final_r, res_final_nxt;

  // Output register
  logic        out_valid_r;
  status_t     out_status_r;
  logic [15:0] out_sample_r;
  logic        out_final_r;
  logic        out_free;

  // Crossfade datapath registers
  logic signed [SB-1:0]  d_r;
  logic signed [SB+16:0] pd_r;
  logic signed [SB+16:0] ps_r;
  logic [SINE_W-1:0]     sin_r;
  logic [SINE_W-1:0]     cos_r;

  // Ring port
  logic               ram_we;
  logic [RING_AW-1:0] ram_waddr;
  logic [SB-1:0]      ram_wdata;
  logic [RING_AW-1:0] ram_raddr;
  logic [SB-1:0]      ram_rdata;

  acs_ram #(
    .WIDTH(SB),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr  (ram_raddr),
    .rdata_r(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Quiet test, shared by push (input sample) and the tail scan (ring data)
  // ---------------------------------------------------------------------------
  logic [SB-1:0]        push_sample;
  logic signed [SB-1:0] q_in;
  logic [SB-1:0]        q_mag;
  logic [SQ_W-1:0]      q_sq;
  logic                 quiet;

  assign push_sample = to_ring(in_sample_in);
  assign q_in        = (state_r == S_IDLE) ? $signed(push_sample) : $signed(ram_rdata);
  assign q_mag       = q_in[SB-1] ? SB'(-q_in) : SB'(q_in);
  assign q_sq        = SQ_W'(q_mag) * SQ_W'(q_mag);
  assign quiet       = CMP_W'(q_sq) < CMP_W'(qlvl_r);

  // ---------------------------------------------------------------------------
  // Splice length arithmetic
  // ---------------------------------------------------------------------------
  logic [13:0]      cap_w;
  logic [CNT_W-1:0] cap_calc;
  logic [CNT_W-1:0] q_min;
  logic [13:0]      mf_w;
  logic [CNT_W-1:0] mf;
  logic [CNT_W-1:0] n_max;
  logic [CNT_W-1:0] n_calc;

  always_comb begin
    cap_w = {1'b0, held_r};
    if ({2'b0, len_r} < cap_w) begin
      cap_w = {2'b0, len_r};
    end
    if (FADE_V < cap_w) begin
      cap_w = FADE_V;
    end
    cap_calc = cap_w[CNT_W-1:0];

    q_min  = (qt_r < qhead_r) ? qt_r : qhead_r;
    mf_w   = (minfade_r < {2'b0, cap_r}) ? minfade_r : {2'b0, cap_r};
    mf     = mf_w[CNT_W-1:0];
    n_max  = (q_min > mf) ? q_min : mf;
    n_calc = (n_max > cap_r) ? cap_r : n_max;
  end

  // Restoring divider step: sine index advance per crossfade step is D / n
  logic [CNT_W:0] div_sh;
  logic           div_ge;
  logic [CNT_W:0] div_rem;

  assign div_sh  = {rem_r[CNT_W-1:0], D_V[bit_r]};
  assign div_ge  = div_sh >= {1'b0, n_r};
  assign div_rem = div_ge ? (div_sh - {1'b0, n_r}) : div_sh;

  // Incremental index: j = floor((2*i*D + n) / (2*n)), remainder kept below 2n
  logic [CNT_W+1:0] acc_sum;
  logic [CNT_W+1:0] two_n;
  logic             acc_ge;

  assign acc_sum = {1'b0, r_r} + {1'b0, b_r};
  assign two_n   = {1'b0, n_r, 1'b0};
  assign acc_ge  = acc_sum >= two_n;

  // Mix: floor((d*cos + s*sin + 16384) / 32768), saturated
  logic signed [SB+17:0] mix_sum;
  logic signed [SB+2:0]  mix_shr;
  logic [SB-1:0]         mix_sat;

  assign mix_sum = (SB+18)'(pd_r) + (SB+18)'(ps_r) + MIX_RND;
  assign mix_shr = $signed(mix_sum[SB+17:15]);
  always_comb begin
    if (mix_shr > MIX_HI) begin
      mix_sat = MIX_HI[SB-1:0];
    end else if (mix_shr < MIX_LO) begin
      mix_sat = MIX_LO[SB-1:0];
    end else begin
      mix_sat = mix_shr[SB-1:0];
    end
  end

  // Pull availability and store occupancy
  logic             pull_avail;
  logic             occ_full;
  logic [HELD_W-1:0] held_new;
  op_t              in_op;

  assign in_op      = op_t'(in_opcode);
  assign pull_avail = (mode_r == MODE_DONE) ? (held_r != '0) : ({1'b0, held_r} > FADE_V);
  assign occ_full   = ({1'b0, held_r} + 14'(len_r)) >= OCC_LIMIT;
  assign held_new   = held_r + HELD_W'(len_r) - HELD_W'(n_r);
  assign out_free   = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    emit_nxt       = emit_r;
    mode_nxt       = mode_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    held_nxt       = held_r;
    len_nxt        = len_r;
    qhead_nxt      = qhead_r;
    loud_nxt       = loud_r;
    start_nxt      = start_r;
    cap_nxt        = cap_r;
    qt_nxt         = qt_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    r_nxt          = r_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    fin_nxt        = fin_r;
    res_status_nxt = res_status_r;
    res_sample_nxt = res_sample_r;
    res_final_nxt  = res_final_r;
    ram_we         = 1'b0;
    ram_waddr      = wp_r;
    ram_wdata      = push_sample;
    ram_raddr      = rp_r;

    unique case (state_r)
      S_IDLE: begin
        if (emit_r) begin
          // hold the finished result until the output register frees
          if (out_free) begin
            emit_nxt = 1'b0;
          end
        end else if (in_valid) begin
          res_status_nxt = ST_OK;
          res_sample_nxt = '0;
          res_final_nxt  = 1'b0;
          emit_nxt       = 1'b1;
          unique case (in_op) inside
            OP_PUSH: begin
              if (mode_r == MODE_DONE || occ_full) begin
                res_status_nxt = ST_REFUSED;
              end else begin
                ram_we  = 1'b1;
                wp_nxt  = wp_r + 1'b1;
                len_nxt = len_r + 1'b1;
                if (!loud_r && quiet) begin
                  if (qhead_r != CNT_SAT) begin
                    qhead_nxt = qhead_r + 1'b1;
                  end
                end else begin
                  loud_nxt = 1'b1;
                end
              end
            end
            OP_CLOSE, OP_FINISH: begin
              if (mode_r != MODE_DONE) begin
                fin_nxt   = (in_op == OP_FINISH);
                start_nxt = rp_r + held_r[RING_AW-1:0];
                cap_nxt   = cap_calc;
                qt_nxt    = '0;
                n_nxt     = '0;
                i_nxt     = '0;
                emit_nxt  = 1'b0;
                if (len_r == '0 || mode_r == MODE_FIRST || held_r == '0) begin
                  state_nxt = S_FIN;
                end else begin
                  state_nxt = S_SCAN_RD;
                end
              end
            end
            OP_PULL: begin
              if (pull_avail) begin
                rp_nxt    = rp_r + 1'b1;
                held_nxt  = held_r - 1'b1;
                emit_nxt  = 1'b0;
                state_nxt = S_PULL;
                if (mode_r == MODE_DONE && held_r == HELD_W'(1)) begin
                  res_final_nxt = 1'b1;
                  mode_nxt      = MODE_FIRST;
                end
              end else begin
                res_status_nxt = ST_EMPTY;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end

      S_PULL: begin
        res_sample_nxt = to_out(ram_rdata);
        emit_nxt       = 1'b1;
        state_nxt      = S_IDLE;
      end

      S_SCAN_RD: begin
        if (qt_r < cap_r) begin
          ram_raddr = start_r - RING_AW'(1) - qt_r;
          state_nxt = S_SCAN_CHK;
        end else begin
          state_nxt = S_SEL;
        end
      end

      S_SCAN_CHK: begin
        if (quiet) begin
          qt_nxt    = qt_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_SEL;
        end
      end

      S_SEL: begin
        n_nxt   = n_calc;
        rem_nxt = '0;
        a_nxt   = '0;
        bit_nxt = BW'(TW - 1);
        i_nxt   = '0;
        if (n_calc == '0) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt = div_rem;
        a_nxt   = {a_r[TW-2:0], div_ge};
        if (bit_r == '0) begin
          b_nxt     = {div_rem[CNT_W-1:0], 1'b0};
          r_nxt     = {1'b0, n_r};
          j_nxt     = '0;
          state_nxt = S_MIX_RD_D;
        end else begin
          bit_nxt = bit_r - 1'b1;
        end
      end

      S_MIX_RD_D: begin
        ram_raddr = start_r - n_r + i_r;
        state_nxt = S_MIX_RD_S;
      end

      S_MIX_RD_S: begin
        ram_raddr = start_r + i_r;
        state_nxt = S_MIX_MUL;
      end

      S_MIX_MUL: begin
        state_nxt = S_MIX_WR;
      end

      S_MIX_WR: begin
        ram_we    = 1'b1;
        ram_waddr = start_r - n_r + i_r;
        ram_wdata = mix_sat;
        i_nxt     = i_r + 1'b1;
        if (acc_ge) begin
          r_nxt = CNT_W'(acc_sum - two_n);
          j_nxt = j_r + a_r + TW'(1);
        end else begin
          r_nxt = acc_sum[CNT_W:0];
          j_nxt = j_r + a_r;
        end
        if (i_r + 1'b1 == n_r) begin
          state_nxt = S_SH_RD;
        end else begin
          state_nxt = S_MIX_RD_D;
        end
      end

      S_SH_RD: begin
        if (i_r < len_r) begin
          ram_raddr = start_r + i_r;
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = start_r + i_r - n_r;
        ram_wdata = ram_rdata;
        i_nxt     = i_r + 1'b1;
        state_nxt = S_SH_RD;
      end

      S_FIN: begin
        held_nxt  = held_new;
        wp_nxt    = start_r + len_r - n_r;
        len_nxt   = '0;
        qhead_nxt = '0;
        loud_nxt  = 1'b0;
        if (len_r != '0) begin
          mode_nxt = MODE_LATER;
        end
        if (fin_r) begin
          // an empty finished utterance drops straight back to first-chunk mode
          mode_nxt = (held_new == '0) ? MODE_FIRST : MODE_DONE;
        end
        emit_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      emit_r      <= 1'b0;
      mode_r      <= MODE_FIRST;
      rp_r        <= '0;
      wp_r        <= '0;
      held_r      <= '0;
      len_r       <= '0;
      qhead_r     <= '0;
      loud_r      <= 1'b0;
      out_valid_r <= 1'b0;
      qlvl_r      <= QUIET_LEVEL_RST;
      minfade_r   <= MIN_FADE_RST;
    end else begin
      state_r <= state_nxt;
      emit_r  <= emit_nxt;
      mode_r  <= mode_nxt;
      rp_r    <= rp_nxt;
      wp_r    <= wp_nxt;
      held_r  <= held_nxt;
      len_r   <= len_nxt;
      qhead_r <= qhead_nxt;
      loud_r  <= loud_nxt;
      // load the output register when a result is ready and the slot frees
      if (state_r == S_IDLE && emit_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_QUIET_LEVEL: qlvl_r    <= cfg_data;
          CFG_MIN_FADE:    minfade_r <= cfg_data[13:0];
          default:         qlvl_r    <= qlvl_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r      <= start_nxt;
    cap_r        <= cap_nxt;
    qt_r         <= qt_nxt;
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    r_r          <= r_nxt;
    rem_r        <= rem_nxt;
    bit_r        <= bit_nxt;
    fin_r        <= fin_nxt;
    res_status_r <= res_status_nxt;
    res_sample_r <= res_sample_nxt;
    res_final_r  <= res_final_nxt;
    // sine/cosine weights follow the current index
    sin_r <= SINE_ROM[j_r];
    cos_r <= SINE_ROM[D_V - j_r];
    if (state_r == S_MIX_RD_S) begin
      d_r <= $signed(ram_rdata);
    end
    if (state_r == S_MIX_MUL) begin
      pd_r <= d_r * $signed({1'b0, cos_r});
      ps_r <= $signed(ram_rdata) * $signed({1'b0, sin_r});
    end
    if (state_r == S_IDLE && emit_r && out_free) begin
      out_status_r <= res_status_r;
      out_sample_r <= res_sample_r;
      out_final_r  <= res_final_r;
    end
  end

  assign in_stall         = (state_r != S_IDLE) || emit_r;
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_sample_out   = $signed(out_sample_r);
  assign out_final_sample = out_final_r;

endmodule

`default_nettype wire

// ----- sv/acs_checker.sv -----
// Port-level checker for the audio chunk crossfade splicer, bound to the top level.
// Depends on acs_pkg.
`default_nettype none

module acs_checker
  import acs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [1:0]            in_opcode,
  input logic signed [15:0]    in_sample_in,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            out_status,
  input logic signed [15:0]    out_sample_out,
  input logic                  out_final_sample,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // the input stalls after every accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted on back-to-back cycles");

  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_sample_out == 16'sd0)
    else $error("nonzero sample with failing status");

  a_final_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_final_sample |-> out_status == ST_OK)
    else $error("final flag on failed pull");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_REFUSED || out_status == ST_EMPTY)
    else $error("undefined status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample_out))
    else $error("stalled result changed");

endmodule

bind audio_chunk_crossfade_splicer_top acs_checker u_acs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_opcode       (in_opcode),
  .in_sample_in    (in_sample_in),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_sample_out  (out_sample_out),
  .out_final_sample(out_final_sample),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready),
  .cfg_index       (cfg_index),
  .cfg_data        (cfg_data)
);

`default_nettype wire
